[hw/rtl/mmsc_pkg.sv]
// ----------------------------------------------------------------------------
// mmsc_pkg
// Shared constants, operation codes and the result record for the
// multi-mode stream checksum.
// ----------------------------------------------------------------------------
`default_nettype none

package mmsc_pkg;

  localparam logic [31:0] POLY_MSB   = 32'h04C1_1DB7;
  localparam logic [31:0] POLY_LSB   = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  localparam int MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_POSIX = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CRC32 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SYSV  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BSD   = 2'd3;

  // shared step unit operations
  localparam int OP_W = 3;

  localparam logic [OP_W-1:0] OP_CRC_MSB = 3'd0;  // one bit, MSB-first CRC
  localparam logic [OP_W-1:0] OP_CRC_LSB = 3'd1;  // one bit, reflected CRC
  localparam logic [OP_W-1:0] OP_SUM     = 3'd2;  // 32-bit wrapping byte add
  localparam logic [OP_W-1:0] OP_BSD     = 3'd3;  // rotate right, add, 16 bits
  localparam logic [OP_W-1:0] OP_FOLD    = 3'd4;  // low half plus high half

  typedef struct packed {
    logic [31:0] checksum;
    logic [63:0] length_report;
    logic        count_overflow;
  } mmsc_result_t;

endpackage

`default_nettype wire

[hw/rtl/multi_mode_stream_checksum.sv]
// ----------------------------------------------------------------------------
// multi_mode_stream_checksum
// POSIX cksum CRC, reflected CRC-32, SysV sum or BSD sum over a byte stream,
// with byte or block count and counter overflow flag at end of stream.
// ----------------------------------------------------------------------------
// Processing: CRC modes step the shared step unit one CRC bit per cycle,
//   sum modes take one add per byte; in_stall holds off each new item until
//   the previous one is done.
// End of stream: POSIX mode appends the length bytes (up to 8) to the CRC;
//   CRC-32 and BSD go straight to the result, SysV folds the sum first.
// Reset: synchronous; mode returns to POSIX, stream state clears, no output.
`default_nettype none

module multi_mode_stream_checksum (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [mmsc_pkg::MODE_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        byte_present,
  input  wire logic                        end_of_stream,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [31:0]                      checksum,
  output logic [63:0]                      length_report,
  output logic                             count_overflow
);
  import mmsc_pkg::*;

  logic         ctrl_idle;
  logic         res_valid;
  logic         out_free;
  logic         accept;
  mmsc_result_t result;

  assign in_stall = !ctrl_idle;
  assign accept   = in_valid && ctrl_idle;
  assign out_free = !out_valid || !out_stall;

  mmsc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .data_byte     (data_byte),
    .byte_present  (byte_present),
    .end_of_stream (end_of_stream),
    .out_free      (out_free),
    .idle          (ctrl_idle),
    .res_valid     (res_valid),
    .result        (result)
  );

  // output register; the sequencer only finishes when this slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      checksum       <= result.checksum;
      length_report  <= result.length_report;
      count_overflow <= result.count_overflow;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mmsc_step_unit.sv]
// ----------------------------------------------------------------------------
// mmsc_step_unit
// Shared arithmetic unit: one CRC bit step, a byte add, a BSD rotate-add
// or an end-around fold of the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsc_step_unit (
  input  wire logic [mmsc_pkg::OP_W-1:0] op,
  input  wire logic [31:0]               acc,
  input  wire logic                      data_bit,
  input  wire logic [7:0]                data_byte,
  output logic [31:0]                    acc_next
);
  import mmsc_pkg::*;

  logic        fb_msb;
  logic        fb_lsb;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic [31:0] add_sum;

  assign fb_msb  = acc[31] ^ data_bit;
  assign fb_lsb  = acc[0] ^ data_bit;
  assign add_sum = add_a + add_b;

  always_comb begin
    add_a = acc;
    add_b = {24'b0, data_byte};
    unique case (op)
      OP_BSD: begin
        add_a = {16'b0, acc[0], acc[15:1]};
      end
      OP_FOLD: begin
        add_a = {16'b0, acc[15:0]};
        add_b = {16'b0, acc[31:16]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (op)
      OP_CRC_MSB: acc_next = {acc[30:0], 1'b0} ^ (fb_msb ? POLY_MSB : 32'b0);
      OP_CRC_LSB: acc_next = {1'b0, acc[31:1]} ^ (fb_lsb ? POLY_LSB : 32'b0);
      OP_BSD:     acc_next = {16'b0, add_sum[15:0]};
      default:    acc_next = add_sum;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/mmsc_ctrl.sv]
// ----------------------------------------------------------------------------
// mmsc_ctrl
// Sequencer, accumulator and byte counter. Drives the shared step unit one
// bit or one add per cycle and builds the end-of-stream result.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsc_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [mmsc_pkg::MODE_W-1:0] cfg_data,
  input  wire logic                        accept,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        byte_present,
  input  wire logic                        end_of_stream,
  input  wire logic                        out_free,
  output logic                             idle,
  output logic                             res_valid,
  output mmsc_pkg::mmsc_result_t           result
);
  import mmsc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CRC    = 3'd1;
  localparam logic [2:0] S_ADD    = 3'd2;
  localparam logic [2:0] S_END    = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_FOLD   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state;
  logic [MODE_W-1:0] mode;
  logic [31:0]       acc;
  logic [63:0]       counter;
  logic              overflow;
  logic [7:0]        shreg;
  logic [63:0]       len_shift;
  logic [2:0]        bit_cnt;
  logic              last;
  logic              in_append;
  logic              fold_second;

  logic [OP_W-1:0]   op;
  logic              data_bit;
  logic [31:0]       acc_next;
  logic [31:0]       start_value;

  mmsc_step_unit u_step (
    .op        (op),
    .acc       (acc),
    .data_bit  (data_bit),
    .data_byte (shreg),
    .acc_next  (acc_next)
  );

  always_comb begin
    op       = OP_SUM;
    data_bit = shreg[7];
    unique case (state)
      S_CRC: begin
        if (mode == MODE_CRC32) begin
          op       = OP_CRC_LSB;
          data_bit = shreg[0];
        end else begin
          op = OP_CRC_MSB;
        end
      end
      S_ADD:   op = (mode == MODE_BSD) ? OP_BSD : OP_SUM;
      S_FOLD:  op = OP_FOLD;
      default: op = OP_SUM;
    endcase
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && out_free;

  always_comb begin
    unique case (mode)
      MODE_POSIX: begin
        result.checksum      = ~acc;
        result.length_report = counter;
      end
      MODE_CRC32: begin
        result.checksum      = acc ^ ALL_ONES32;
        result.length_report = counter;
      end
      MODE_SYSV: begin
        result.checksum      = {16'b0, acc[15:0]};
        result.length_report = {9'b0, counter[63:9]} + {63'b0, |counter[8:0]};
      end
      default: begin
        result.checksum      = {16'b0, acc[15:0]};
        result.length_report = {10'b0, counter[63:10]} + {63'b0, |counter[9:0]};
      end
    endcase
    result.count_overflow = overflow;
  end

  assign start_value = (cfg_data == MODE_CRC32) ? ALL_ONES32 : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= MODE_POSIX;
      acc         <= 32'b0;
      counter     <= 64'b0;
      overflow    <= 1'b0;
      last        <= 1'b0;
      in_append   <= 1'b0;
      fold_second <= 1'b0;
      bit_cnt     <= 3'd0;
    end else if (cfg_write) begin
      // a mode write drops any stream in progress
      state    <= S_IDLE;
      mode     <= cfg_data;
      acc      <= start_value;
      counter  <= 64'b0;
      overflow <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            shreg     <= data_byte;
            last      <= end_of_stream;
            in_append <= 1'b0;
            bit_cnt   <= 3'd0;
            if (byte_present) begin
              if (&counter) overflow <= 1'b1;
              else          counter  <= counter + 64'd1;
              state <= (mode == MODE_POSIX || mode == MODE_CRC32) ? S_CRC : S_ADD;
            end else if (end_of_stream) begin
              state <= S_END;
            end
          end
        end
        S_CRC: begin
          acc     <= acc_next;
          bit_cnt <= bit_cnt + 3'd1;
          if (mode == MODE_CRC32) shreg <= {1'b0, shreg[7:1]};
          else                    shreg <= {shreg[6:0], 1'b0};
          if (bit_cnt == 3'd7) begin
            if (in_append)  state <= S_APPEND;
            else if (last)  state <= S_END;
            else            state <= S_IDLE;
          end
        end
        S_ADD: begin
          acc   <= acc_next;
          state <= last ? S_END : S_IDLE;
        end
        S_END: begin
          fold_second <= 1'b0;
          len_shift   <= counter;
          unique case (mode)
            MODE_POSIX: state <= S_APPEND;
            MODE_SYSV:  state <= S_FOLD;
            default:    state <= S_DONE;
          endcase
        end
        S_APPEND: begin
          // length bytes, least significant first, until none remain
          if (len_shift == 64'b0) begin
            state <= S_DONE;
          end else begin
            shreg     <= len_shift[7:0];
            len_shift <= {8'b0, len_shift[63:8]};
            in_append <= 1'b1;
            bit_cnt   <= 3'd0;
            state     <= S_CRC;
          end
        end
        S_FOLD: begin
          acc         <= acc_next;
          fold_second <= 1'b1;
          if (fold_second) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            acc      <= (mode == MODE_CRC32) ? ALL_ONES32 : 32'b0;
            counter  <= 64'b0;
            overflow <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
